@@ rtl/core/max_heap_priority_queue_defines.svh @@
// Assertion macros for the max-heap priority queue.
// Used by the top level only; relies on the aclk / aresetn port names.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MHPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mhpq_pkg.sv @@
// Shared types and constants for the max-heap priority queue.
// No dependencies; imported by every module of the block.
package mhpq_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = CNT_W + 1;
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [CHILD_W-1:0]      child_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Request from the sequencer to the heap storage
    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        key_t wr_data;
        logic rd_en;
        idx_t rd_addr_a;
        idx_t rd_addr_b;
    } mem_req_t;

    // Finished result handed to the output register
    typedef struct packed {
        key_t    removed_key;
        key_t    top_key;
        cnt_t    count;
        status_t status;
    } result_t;

endpackage

@@ rtl/core/max_heap_priority_queue.sv @@
// Max-heap priority queue of 128 signed 32-bit keys. A request is an insert
// (s_command 0) or a delete-max (s_command 1) and returns exactly one result
// with the removed key, the new maximum, the count and a status. s_ready is
// high only while the sequencer is idle; one request is worked at a time.
// An insert climbs the key one level per parent read and compare; a delete
// moves the last entry to the root and sifts it down one level per read of
// both children. The work is paced by the registered storage reads and the
// one shared comparator, used once per level on insert and twice per level
// on delete. Rejected requests (insert when full, delete when empty) go
// straight to the result. The result sits in an output register, so the next
// request can be taken while a result waits.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_ram and the defines header.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic signed [KEY_W-1:0] s_key,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [KEY_W-1:0] m_removed_key,
    output logic signed [KEY_W-1:0] m_top_key,
    output logic [ENTRY_W-1:0]      m_entry_count,
    output logic [1:0]              m_status
);

    mem_req_t mem_req;
    key_t     rd_data_a;
    key_t     rd_data_b;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     m_valid_reg;
    key_t     removed_reg;
    key_t     top_reg;
    logic [ENTRY_W-1:0] count_reg;
    logic [1:0] status_reg;

    mhpq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_key     (s_key),
        .mem_req   (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    mhpq_ram u_ram (
        .aclk      (aclk),
        .req       (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            removed_reg <= res.removed_key;
            top_reg     <= res.top_key;
            count_reg   <= ENTRY_W'(res.count);
            status_reg  <= res.status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_removed_key = removed_reg;
    assign m_top_key     = top_reg;
    assign m_entry_count = count_reg;
    assign m_status      = status_reg;

    // checks on the block's own behavior
    `MHPQ_ASSERT_NEXT(a_busy_after_req, s_valid && s_ready, !s_ready, "ready after request")
    `MHPQ_ASSERT_IMPL(a_empty_top_zero, m_valid && (m_entry_count == '0), m_top_key == '0, "top not zero when empty")
    `MHPQ_ASSERT_IMPL(a_reject_empty, m_valid && (m_status == ST_EMPTY), (m_entry_count == '0) && (m_removed_key == '0), "bad empty reject")
    `MHPQ_ASSERT_IMPL(a_reject_full, m_valid && (m_status == ST_FULL), m_entry_count == ENTRY_W'(CAPACITY), "bad full reject")

endmodule

@@ rtl/core/mhpq_ram.sv @@
// Heap storage: one write port, two read ports with registered data.
// Depends on mhpq_pkg.
module mhpq_ram
    import mhpq_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output key_t     rd_data_a,
    output key_t     rd_data_b
);

    key_t mem [CAPACITY];

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read ports hold their data until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_a <= mem[req.rd_addr_a];
            rd_data_b <= mem[req.rd_addr_b];
        end
    end

endmodule

@@ rtl/core/mhpq_cmp.sv @@
// Shared signed key comparator used by every sift step.
// Depends on mhpq_pkg.
module mhpq_cmp
    import mhpq_pkg::*;
(
    input  key_t a,
    input  key_t b,
    output logic gt
);

    // two's complement greater-than
    assign gt = $signed(a) > $signed(b);

endmodule

@@ rtl/core/mhpq_ctrl.sv @@
// Sequencer for insert / delete-max: hole-based sift-up and sift-down.
// Depends on mhpq_pkg and mhpq_cmp; drives mhpq_ram through a mem_req_t.
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_command,
    input  key_t     s_key,
    output mem_req_t mem_req,
    input  key_t     rd_data_a,
    input  key_t     rd_data_b,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_RD   = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_DN_LAST = 8'b0000_1000,
        S_DN_RD   = 8'b0001_0000,
        S_DN_CMPL = 8'b0010_0000,
        S_DN_CMPR = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    idx_t    pos_reg, pos_next;
    key_t    val_reg, val_next;
    key_t    cand_reg, cand_next;
    logic    cand_left_reg, cand_left_next;
    key_t    removed_reg, removed_next;
    status_t status_reg, status_next;
    key_t    top_reg;

    idx_t    parent;
    child_t  left_idx;
    child_t  right_idx;
    logic    left_ok;
    logic    right_ok;
    key_t    cmp_a;
    key_t    cmp_b;
    logic    cmp_gt;
    cnt_t    count_dec;

    // heap index arithmetic around the current hole
    assign parent    = (pos_reg - idx_t'(1)) >> 1;
    assign left_idx  = child_t'({pos_reg, 1'b0}) + child_t'(1);
    assign right_idx = left_idx + child_t'(1);
    assign left_ok   = left_idx < child_t'(count_reg);
    assign right_ok  = right_idx < child_t'(count_reg);
    assign count_dec = count_reg - cnt_t'(1);

    mhpq_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .gt (cmp_gt)
    );

    // comparator operand select
    always_comb begin
        cmp_a = val_reg;
        cmp_b = rd_data_a;
        unique case (state_reg)
            S_DN_CMPL: begin
                cmp_a = rd_data_a;
                cmp_b = val_reg;
            end
            S_DN_CMPR: begin
                cmp_a = rd_data_b;
                cmp_b = cand_reg;
            end
            default: begin
                cmp_a = val_reg;
                cmp_b = rd_data_a;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        pos_next          = pos_reg;
        val_next          = val_reg;
        cand_next         = cand_reg;
        cand_left_next    = cand_left_reg;
        removed_next      = removed_reg;
        status_next       = status_reg;
        mem_req           = '0;
        res_valid         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    removed_next = '0;
                    status_next  = ST_DONE;
                    if (s_command == CMD_INSERT) begin
                        if (count_reg == cnt_t'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end else begin
                            pos_next   = count_reg[IDX_W-1:0];
                            val_next   = s_key;
                            count_next = count_reg + cnt_t'(1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end else begin
                            removed_next      = top_reg;
                            count_next        = count_dec;
                            mem_req.rd_en     = 1'b1;
                            mem_req.rd_addr_a = count_dec[IDX_W-1:0];
                            mem_req.rd_addr_b = count_dec[IDX_W-1:0];
                            state_next        = S_DN_LAST;
                        end
                    end
                end
            end

            // sift-up: fetch parent, or drop the key at the root
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pos_reg;
                    mem_req.wr_data = val_reg;
                    state_next      = S_FIN;
                end else begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = parent;
                    mem_req.rd_addr_b = parent;
                    state_next        = S_UP_CMP;
                end
            end

            // move a smaller parent down into the hole, else place the key
            S_UP_CMP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                if (cmp_gt) begin
                    mem_req.wr_data = rd_data_a;
                    pos_next        = parent;
                    state_next      = S_UP_RD;
                end else begin
                    mem_req.wr_data = val_reg;
                    state_next      = S_FIN;
                end
            end

            // last entry becomes the key sifted down from the root
            S_DN_LAST: begin
                val_next   = rd_data_a;
                pos_next   = '0;
                state_next = S_DN_RD;
            end

            S_DN_RD: begin
                if (!left_ok) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pos_reg;
                    mem_req.wr_data = val_reg;
                    state_next      = S_FIN;
                end else begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = left_idx[IDX_W-1:0];
                    mem_req.rd_addr_b = right_idx[IDX_W-1:0];
                    state_next        = S_DN_CMPL;
                end
            end

            // left child against the moving key
            S_DN_CMPL: begin
                cand_left_next = cmp_gt;
                cand_next      = cmp_gt ? rd_data_a : val_reg;
                state_next     = S_DN_CMPR;
            end

            // right child against the winner so far; ties keep the left
            S_DN_CMPR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                if (right_ok && cmp_gt) begin
                    mem_req.wr_data = rd_data_b;
                    pos_next        = right_idx[IDX_W-1:0];
                    state_next      = S_DN_RD;
                end else if (cand_left_reg) begin
                    mem_req.wr_data = cand_reg;
                    pos_next        = left_idx[IDX_W-1:0];
                    state_next      = S_DN_RD;
                end else begin
                    mem_req.wr_data = val_reg;
                    state_next      = S_FIN;
                end
            end

            S_FIN: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    assign res.removed_key = removed_reg;
    assign res.top_key     = (count_reg != '0) ? top_reg : key_t'(0);
    assign res.count       = count_reg;
    assign res.status      = status_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cand_reg      <= cand_next;
        cand_left_reg <= cand_left_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
    end

    // shadow copy of the root, follows every write to index zero
    always_ff @(posedge aclk) begin
        if (mem_req.wr_en && (mem_req.wr_addr == '0)) begin
            top_reg <= mem_req.wr_data;
        end
    end

endmodule
